/* hw/rtl/cld_pkg.sv */
// package for the coalescing lookup dispatcher
// operation and result codes, default sizes and stream word widths; no dependencies
package cld_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int CACHE_DEPTH_DEF  = 16;
  localparam int KEY_BITS_DEF     = 32;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  localparam logic [1:0] OP_LOOKUP   = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_ABORT    = 2'd2;

  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_FAIL   = 2'd1;
  localparam logic [1:0] KIND_ISSUE  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

endpackage

/* hw/rtl/cld_ram.sv */
// simple dual-port memory with registered read data
// used for the request queue and the result cache; no dependencies
module cld_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/coalescing_lookup_dispatcher_unit.sv */
// top level of the coalescing lookup dispatcher: sequencer, channel table, result staging
// depends on cld_pkg and cld_ram
//
// input stream: tuser carries the operation (lookup, completion, abort), tdata the key,
// client, completed channel and resolved address. result stream: tuser carries the kind
// (answer, fail, issue, reject), tdata the client, key, channel and address, tlast marks
// the final result word caused by one input word.
// one input word is taken at a time; in_tready is high only while the sequencer idles.
// the sequencer walks the cache and the queue one entry per cycle, unless it holds for
// a stalled result, with one shared key comparator. a lookup scans the cache, then the
// queue. a completion scans the queue, compacting it for each served client, then steps
// over the channels for reassignment, scanning the queue for each free one, and closes.
// removing a queue entry is a copy pass over the entries behind it, one a cycle.
// results are staged one word ahead so tlast can be set on the final one; when the
// receiver stalls the sequencer holds at the next result until the output register frees.
// after reset the queue, cache and channels are empty; no clearing pass is needed since
// entries are qualified by fill counts and channel busy bits.
module coalescing_lookup_dispatcher_unit #(
  parameter int NUM_CHANNELS = cld_pkg::NUM_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = cld_pkg::QUEUE_DEPTH_DEF,
  parameter int CACHE_DEPTH  = cld_pkg::CACHE_DEPTH_DEF,
  parameter int KEY_BITS     = cld_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // key[31:0], client_tag[39:32], done_channel[41:40], resolved_address[73:42]
  input  logic [cld_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_client[7:0], out_key[39:8], out_channel[41:40], out_address[73:42]
  output logic [cld_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);

  import cld_pkg::*;

  localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW   = $clog2(NUM_CHANNELS + 1);
  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CAW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CCW  = $clog2(CACHE_DEPTH + 1);
  localparam int MAXD = (QUEUE_DEPTH > CACHE_DEPTH) ? QUEUE_DEPTH : CACHE_DEPTH;
  localparam int IW   = $clog2(MAXD + 1);
  localparam int QEW  = KW + 8 + 1 + CHW;
  localparam int CEW  = KW + 32;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LC   = 4'd1;
  localparam logic [3:0] S_LQ   = 4'd2;
  localparam logic [3:0] S_CQ   = 4'd3;
  localparam logic [3:0] S_SH   = 4'd4;
  localparam logic [3:0] S_AB   = 4'd5;
  localparam logic [3:0] S_AS   = 4'd6;
  localparam logic [3:0] S_AW   = 4'd7;
  localparam logic [3:0] S_AM   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]     st_r, st_nxt, ret_r, ret_nxt;
  logic [IW-1:0]  idx_r, idx_nxt, sav_r, sav_nxt, idx_m1;
  logic [CW-1:0]  ch_r, ch_nxt;
  logic [QCW-1:0] q_cnt_r, q_cnt_nxt;
  logic [CCW-1:0] c_cnt_r, c_cnt_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  logic [7:0]     client_r, client_nxt;
  logic [1:0]     c_r, c_nxt;
  logic [31:0]    addr_r, addr_nxt;

  logic [NUM_CHANNELS-1:0] busy_r, busy_nxt;
  logic [KW-1:0]           chkey_r [NUM_CHANNELS];
  logic                    chk_we;
  logic [CHW-1:0]          chk_wa;

  logic           q_we;
  logic [QAW-1:0] q_wa;
  logic [QEW-1:0] q_wd, q_rd;
  logic           c_we;
  logic [CEW-1:0] c_rd;

  logic [KW-1:0]  q_rd_key, c_rd_key;
  logic [7:0]     q_rd_client;
  logic           q_rd_wait;
  logic [CHW-1:0] q_rd_ch;
  logic [31:0]    c_rd_addr;
  logic           eq;

  logic           free_found;
  logic [CHW-1:0] free_ch;
  logic           in_acc, cvalid, q_full, at_qend, at_cend;
  logic [CHW-1:0] in_ch, c_ch, ch_idx;

  logic        emit_req, can_emit, hold;
  logic [1:0]  e_kind;
  logic [7:0]  e_client;
  logic [31:0] e_key, e_addr;
  logic [1:0]  e_chan;

  logic        pend_v_r, pend_v_nxt;
  logic [1:0]  pend_kind_r, pend_chan_r;
  logic [7:0]  pend_client_r;
  logic [31:0] pend_key_r, pend_addr_r;

  logic        out_v_r, out_v_nxt, out_load, out_last_sel;
  logic [1:0]  out_kind_r, out_chan_r;
  logic [7:0]  out_client_r;
  logic [31:0] out_key_r, out_addr_r;
  logic        out_last_r;

  cld_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(QEW)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_wa),
    .wdata (q_wd),
    .raddr (idx_nxt[QAW-1:0]),
    .rdata (q_rd)
  );

  cld_ram #(.DEPTH(CACHE_DEPTH), .WIDTH(CEW)) u_cache (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_cnt_r[CAW-1:0]),
    .wdata ({in_tdata[73:42], chkey_r[in_ch]}),
    .raddr (idx_nxt[CAW-1:0]),
    .rdata (c_rd)
  );

  assign q_rd_key    = q_rd[KW-1:0];
  assign q_rd_client = q_rd[KW+7:KW];
  assign q_rd_wait   = q_rd[KW+8];
  assign q_rd_ch     = q_rd[QEW-1:KW+9];
  assign c_rd_key    = c_rd[KW-1:0];
  assign c_rd_addr   = c_rd[CEW-1:KW];

  // the shared key comparator
  assign eq = ((st_r == S_LC) ? c_rd_key : q_rd_key) == key_r;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_ch     = in_tdata[40 +: CHW];
  assign c_ch      = c_r[CHW-1:0];
  assign ch_idx    = ch_r[CHW-1:0];
  assign cvalid    = ({1'b0, in_tdata[41:40]} < 3'(NUM_CHANNELS)) ? busy_r[in_ch] : 1'b0;
  assign q_full    = (q_cnt_r == QCW'(QUEUE_DEPTH));
  assign at_qend   = (idx_r == IW'(q_cnt_r));
  assign at_cend   = (idx_r == IW'(c_cnt_r));
  assign idx_m1    = idx_r - IW'(1);

  always_comb begin
    free_found = 1'b0;
    free_ch    = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!busy_r[i] && !free_found) begin
        free_found = 1'b1;
        free_ch    = CHW'(i);
      end
    end
  end

  // result decode per state
  always_comb begin
    emit_req = 1'b0;
    e_kind   = KIND_ANSWER;
    e_client = '0;
    e_key    = '0;
    e_chan   = '0;
    e_addr   = '0;
    case (st_r)
      S_LC: begin
        if (at_cend) begin
          if (q_full) begin
            emit_req = 1'b1;
            e_kind   = KIND_REJECT;
            e_client = client_r;
          end
        end else if (eq) begin
          emit_req = 1'b1;
          e_kind   = KIND_ANSWER;
          e_client = client_r;
          e_addr   = c_rd_addr;
        end
      end
      S_LQ: begin
        if (at_qend && free_found) begin
          emit_req = 1'b1;
          e_kind   = KIND_ISSUE;
          e_key    = 32'(key_r);
          e_chan   = 2'(free_ch);
        end
      end
      S_CQ: begin
        if (!at_qend && !q_rd_wait && q_rd_ch == c_ch) begin
          emit_req = 1'b1;
          e_kind   = (addr_r == '0) ? KIND_FAIL : KIND_ANSWER;
          e_client = q_rd_client;
          e_addr   = addr_r;
        end
      end
      S_AM: begin
        if (at_qend) begin
          emit_req = 1'b1;
          e_kind   = KIND_ISSUE;
          e_key    = 32'(key_r);
          e_chan   = 2'(ch_idx);
        end
      end
      default: begin
      end
    endcase
  end

  assign can_emit = !pend_v_r || !out_v_r || out_tready;
  assign hold     = emit_req && !can_emit;

  always_comb begin
    st_nxt       = st_r;
    ret_nxt      = ret_r;
    idx_nxt      = idx_r;
    sav_nxt      = sav_r;
    ch_nxt       = ch_r;
    q_cnt_nxt    = q_cnt_r;
    c_cnt_nxt    = c_cnt_r;
    key_nxt      = key_r;
    client_nxt   = client_r;
    c_nxt        = c_r;
    addr_nxt     = addr_r;
    busy_nxt     = busy_r;
    chk_we       = 1'b0;
    chk_wa       = free_ch;
    q_we         = 1'b0;
    q_wa         = q_cnt_r[QAW-1:0];
    q_wd         = q_rd;
    c_we         = 1'b0;
    pend_v_nxt   = pend_v_r;
    out_load     = 1'b0;
    out_last_sel = 1'b0;
    if (!hold) begin
      if (emit_req) begin
        pend_v_nxt = 1'b1;
        out_load   = pend_v_r;
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            key_nxt    = in_tdata[KW-1:0];
            client_nxt = in_tdata[39:32];
            c_nxt      = in_tdata[41:40];
            addr_nxt   = in_tdata[73:42];
            idx_nxt    = '0;
            case (in_tuser)
              OP_LOOKUP: st_nxt = S_LC;
              OP_COMPLETE: begin
                if (cvalid) begin
                  if (in_tdata[73:42] != '0 && c_cnt_r < CCW'(CACHE_DEPTH)) begin
                    c_we      = 1'b1;
                    c_cnt_nxt = c_cnt_r + CCW'(1);
                  end
                  st_nxt = S_CQ;
                end else begin
                  st_nxt = S_FIN;
                end
              end
              OP_ABORT: st_nxt = S_AB;
              default: st_nxt = S_FIN;
            endcase
          end
        end
        S_LC: begin
          if (at_cend) begin
            if (q_full) begin
              st_nxt = S_FIN;
            end else begin
              idx_nxt = '0;
              st_nxt  = S_LQ;
            end
          end else if (eq) begin
            st_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_LQ: begin
          if (at_qend) begin
            q_we      = 1'b1;
            q_cnt_nxt = q_cnt_r + QCW'(1);
            if (free_found) begin
              q_wd             = {free_ch, 1'b0, client_r, key_r};
              busy_nxt[free_ch] = 1'b1;
              chk_we           = 1'b1;
            end else begin
              q_wd = {CHW'(0), 1'b1, client_r, key_r};
            end
            st_nxt = S_FIN;
          end else if (eq) begin
            q_we      = 1'b1;
            q_cnt_nxt = q_cnt_r + QCW'(1);
            q_wd      = {q_rd_ch, q_rd_wait, client_r, key_r};
            st_nxt    = S_FIN;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_CQ: begin
          if (at_qend) begin
            busy_nxt[c_ch] = 1'b0;
            ch_nxt         = '0;
            st_nxt         = S_AS;
          end else if (emit_req) begin
            sav_nxt = idx_r;
            ret_nxt = S_CQ;
            idx_nxt = idx_r + IW'(1);
            st_nxt  = S_SH;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_SH: begin
          if (at_qend) begin
            q_cnt_nxt = q_cnt_r - QCW'(1);
            idx_nxt   = sav_r;
            st_nxt    = ret_r;
          end else begin
            q_we    = 1'b1;
            q_wa    = idx_m1[QAW-1:0];
            q_wd    = q_rd;
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_AB: begin
          if (at_qend) begin
            st_nxt = S_FIN;
          end else if (q_rd_client == client_r) begin
            sav_nxt = idx_r;
            ret_nxt = S_FIN;
            idx_nxt = idx_r + IW'(1);
            st_nxt  = S_SH;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_AS: begin
          if (ch_r == CW'(NUM_CHANNELS)) begin
            st_nxt = S_FIN;
          end else if (busy_r[ch_idx]) begin
            ch_nxt = ch_r + CW'(1);
          end else begin
            idx_nxt = '0;
            st_nxt  = S_AW;
          end
        end
        S_AW: begin
          if (at_qend) begin
            st_nxt = S_FIN;
          end else if (q_rd_wait) begin
            key_nxt = q_rd_key;
            st_nxt  = S_AM;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_AM: begin
          if (at_qend) begin
            busy_nxt[ch_idx] = 1'b1;
            chk_we           = 1'b1;
            chk_wa           = ch_idx;
            ch_nxt           = ch_r + CW'(1);
            st_nxt           = S_AS;
          end else begin
            if (q_rd_wait && eq) begin
              q_we = 1'b1;
              q_wa = idx_r[QAW-1:0];
              q_wd = {ch_idx, 1'b0, q_rd_client, q_rd_key};
            end
            idx_nxt = idx_r + IW'(1);
          end
        end
        S_FIN: begin
          if (pend_v_r) begin
            if (!out_v_r || out_tready) begin
              out_load     = 1'b1;
              out_last_sel = 1'b1;
              pend_v_nxt   = 1'b0;
              st_nxt       = S_IDLE;
            end
          end else begin
            st_nxt = S_IDLE;
          end
        end
        default: st_nxt = S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      q_cnt_r  <= '0;
      c_cnt_r  <= '0;
      busy_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      q_cnt_r  <= q_cnt_nxt;
      c_cnt_r  <= c_cnt_nxt;
      busy_r   <= busy_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    idx_r    <= idx_nxt;
    sav_r    <= sav_nxt;
    ch_r     <= ch_nxt;
    key_r    <= key_nxt;
    client_r <= client_nxt;
    c_r      <= c_nxt;
    addr_r   <= addr_nxt;
    if (chk_we) begin
      chkey_r[chk_wa] <= key_r;
    end
    if (emit_req && !hold) begin
      pend_kind_r   <= e_kind;
      pend_client_r <= e_client;
      pend_key_r    <= e_key;
      pend_chan_r   <= e_chan;
      pend_addr_r   <= e_addr;
    end
    if (out_load) begin
      out_kind_r   <= pend_kind_r;
      out_client_r <= pend_client_r;
      out_key_r    <= pend_key_r;
      out_chan_r   <= pend_chan_r;
      out_addr_r   <= pend_addr_r;
      out_last_r   <= out_last_sel;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_addr_r, out_chan_r, out_key_r, out_client_r};

endmodule

/* hw/rtl/cld_checker.sv */
// port-level checks for the coalescing lookup dispatcher, bound to the top level
// depends on cld_pkg and coalescing_lookup_dispatcher_unit
module cld_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cld_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);

  import cld_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after accepting
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  // issue words carry no client
  a_issue_client: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ISSUE |-> out_tdata[7:0] == 8'd0)
    else $error("issue word with a client");

  // a reject is the only result of its word
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REJECT |-> out_tlast)
    else $error("reject not marked last");

endmodule

bind coalescing_lookup_dispatcher_unit cld_checker u_cld_checker (.*);
